@@ design/lifetime_best_fit_arena_planner_assert.svh @@
// Assertion macros for the arena planner
`ifndef LIFETIME_BEST_FIT_ARENA_PLANNER_ASSERT_SVH
`define LIFETIME_BEST_FIT_ARENA_PLANNER_ASSERT_SVH

// a implies b on the same edge
`define LBF_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b on the next edge
`define LBF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

@@ design/lbfap_pkg.sv @@
`default_nettype none
package lbfap_pkg;
    localparam int FREE_ENTRIES   = 64;
    localparam int ACTIVE_ENTRIES = 64;
    localparam int ADDR_BITS      = 32;
    localparam int STEP_BITS      = 16;
    localparam int ALIGN_BYTES    = 64;
    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int AW = $clog2(ACTIVE_ENTRIES);
    localparam int ALIGN_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [STEP_BITS-1:0] t_step;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_FREE_FULL = 3'd3,
        ST_LIVE_FULL = 3'd4,
        ST_ORDER     = 3'd5
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic       clear;      // clear tables (valid bits, mark, previous begin)
        logic       load;       // capture request
        logic       set_prev;   // previous_begin <= begin
        logic       live_rd;    // read active entry at live index
        logic       scan_clr;   // reset free-scan accumulators
        logic       free_rd;    // read free entry at free index
        logic       give_apply; // apply give-back result, retire active entry
        logic       fit_apply;  // apply best-fit / growth, write active entry
        logic [AW-1:0] live_idx;
        logic [FW-1:0] free_idx;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic order_bad;
        logic size_bad;
        logic live_retire;  // read active entry is used and expired
        logic give_ok;      // give-back can be applied
        logic slot_found;   // some active entry free after retirement
        logic fit_ok;       // placement would not overflow
    } t_stat;
endpackage
`default_nettype wire

@@ design/lbfap_ctrl.sv @@
`default_nettype none
module lbfap_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_first,
    output logic                o_busy,
    output logic                o_done,
    output lbfap_pkg::t_status  o_status,
    output lbfap_pkg::t_cmd     o_cmd,
    input  lbfap_pkg::t_stat    i_stat
);
    import lbfap_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_LREAD, S_LTEST, S_FSCAN, S_FWAIT, S_GIVE, S_FIT
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_li;
    logic [FW-1:0] r_fi;
    logic r_mode;   // 0 give-back scan, 1 fit scan
    logic r_first;

    always_comb begin
        o_cmd = '0;
        o_cmd.live_idx = r_li;
        o_cmd.free_idx = r_fi;
        o_cmd.clear    = (r_state == S_CHECK) && r_first;
        o_cmd.live_rd  = (r_state == S_LREAD);
        o_cmd.free_rd  = (r_state == S_FSCAN);
        o_cmd.give_apply = (r_state == S_GIVE) && i_stat.give_ok;
        o_cmd.fit_apply  = (r_state == S_FIT) && i_stat.slot_found && i_stat.fit_ok;
        o_cmd.load     = i_start && !o_busy;
        o_cmd.set_prev = (r_state == S_CHECK) && !i_stat.order_bad && !i_stat.size_bad;
        o_cmd.scan_clr = (r_state == S_LTEST) || (r_state == S_GIVE);
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_li     <= '0;
            r_fi     <= '0;
            r_mode   <= 1'b0;
            r_first  <= 1'b0;
            o_done   <= 1'b0;
            o_status <= ST_OK;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_first <= i_first;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // clear takes effect this edge; checks see post-clear state
                    if (i_stat.order_bad) begin
                        o_status <= ST_ORDER;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (i_stat.size_bad) begin
                        o_status <= ST_BAD_SIZE;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_li    <= '0;
                        r_state <= S_LREAD;
                    end
                end
                S_LREAD: r_state <= S_LTEST;
                S_LTEST: begin
                    r_fi <= '0;
                    if (i_stat.live_retire) begin
                        r_mode  <= 1'b0;
                        r_state <= S_FSCAN;
                    end else if (r_li == AW'(ACTIVE_ENTRIES - 1)) begin
                        r_mode  <= 1'b1;
                        r_state <= S_FSCAN;
                    end else begin
                        r_li    <= r_li + 1'b1;
                        r_state <= S_LREAD;
                    end
                end
                S_FSCAN: begin
                    if (r_fi == FW'(FREE_ENTRIES - 1)) begin
                        r_state <= S_FWAIT;
                    end
                    r_fi <= r_fi + 1'b1;
                end
                S_FWAIT: r_state <= r_mode ? S_FIT : S_GIVE;
                S_GIVE: begin
                    r_fi <= '0;
                    if (!i_stat.give_ok) begin
                        o_status <= ST_FREE_FULL;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_li == AW'(ACTIVE_ENTRIES - 1)) begin
                        r_mode  <= 1'b1;
                        r_state <= S_FSCAN;
                    end else begin
                        r_li    <= r_li + 1'b1;
                        r_state <= S_LREAD;
                    end
                end
                S_FIT: begin
                    if (!i_stat.slot_found) o_status <= ST_LIVE_FULL;
                    else if (!i_stat.fit_ok) o_status <= ST_OVERFLOW;
                    else o_status <= ST_OK;
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "lifetime_best_fit_arena_planner_assert.svh"
    `LBF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `LBF_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `LBF_ASSERT_IMP(a_one_apply, i_clk, i_rst_n, 1'b1, !(o_cmd.give_apply && o_cmd.fit_apply))
endmodule
`default_nettype wire

@@ design/lbfap_dp.sv @@
`default_nettype none
module lbfap_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lbfap_pkg::t_cmd      i_cmd,
    output lbfap_pkg::t_stat     o_stat,
    input  wire [15:0]           i_buffer_id,
    input  wire [15:0]           i_live_begin,
    input  wire [15:0]           i_live_end,
    input  wire [31:0]           i_reserved_bytes,
    input  wire                  i_ok,
    output logic [15:0]          o_placed_id,
    output logic [31:0]          o_offset,
    output logic [31:0]          o_high_water
);
    import lbfap_pkg::*;

    // tables
    t_addr f_start [FREE_ENTRIES];
    t_addr f_len   [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0] r_fused;
    t_step l_until [ACTIVE_ENTRIES];
    t_addr l_addr  [ACTIVE_ENTRIES];
    t_addr l_len   [ACTIVE_ENTRIES];
    logic [ACTIVE_ENTRIES-1:0] r_lused;

    t_addr r_water;
    t_step r_prev;
    logic [15:0] r_id;
    t_step r_begin, r_end;
    logic [31:0] r_size;

    // read registers
    t_step r_lu;
    t_addr r_la, r_ll;
    t_addr r_fs, r_fl;
    logic  r_fv;
    logic [FW-1:0] r_fi_d;

    // give-back scan accumulators
    logic r_left_v, r_right_v, r_spare_v;
    logic [FW-1:0] r_left, r_right, r_spare;
    t_addr r_left_len, r_right_len;
    // fit scan accumulators
    logic r_best_v, r_edge_v;
    logic [FW-1:0] r_best, r_edge;
    t_addr r_best_len, r_best_st, r_edge_len, r_edge_st;

    t_addr size_a;
    assign size_a = t_addr'(r_size);

    logic size_bad;
    always_comb begin
        size_bad = (r_size == '0);
        if (ALIGN_BYTES > 1 && (r_size[ALIGN_W-1:0] != '0)) size_bad = 1'b1;
        if (ADDR_BITS < 32 && ({32'd0, r_size} > 64'((64'd1 << ADDR_BITS) - 1)))
            size_bad = 1'b1;
    end

    logic [AW-1:0] slot;
    logic slot_v;
    always_comb begin
        slot = '0;
        slot_v = 1'b0;
        for (int i = ACTIVE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_lused[i]) begin
                slot = AW'(i);
                slot_v = 1'b1;
            end
        end
    end

    // growth
    t_addr grow, at;
    logic [ADDR_BITS:0] grow_sum;
    always_comb begin
        grow = r_edge_v ? size_a - r_edge_len : size_a;
        at   = r_edge_v ? r_edge_st : r_water;
        grow_sum = {1'b0, r_water} + {1'b0, grow};
    end

    always_comb begin
        o_stat.order_bad   = r_begin < (i_cmd.clear ? '0 : r_prev);
        o_stat.size_bad    = size_bad;
        o_stat.live_retire = r_lused[i_cmd.live_idx] && (r_lu <= r_begin);
        o_stat.give_ok     = r_left_v || r_right_v || r_spare_v;
        o_stat.slot_found  = slot_v;
        o_stat.fit_ok      = r_best_v || !grow_sum[ADDR_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.live_rd) begin
            r_lu <= l_until[i_cmd.live_idx];
            r_la <= l_addr[i_cmd.live_idx];
            r_ll <= l_len[i_cmd.live_idx];
        end
        r_fs <= f_start[i_cmd.free_idx];
        r_fl <= f_len[i_cmd.free_idx];
        r_fi_d <= i_cmd.free_idx;
        if (i_cmd.give_apply) begin
            if (r_left_v) begin
                f_len[r_left] <= r_left_len + r_ll + (r_right_v ? r_right_len : '0);
            end else if (r_right_v) begin
                f_start[r_right] <= r_la;
                f_len[r_right]   <= r_right_len + r_ll;
            end else begin
                f_start[r_spare] <= r_la;
                f_len[r_spare]   <= r_ll;
            end
        end
        if (i_cmd.fit_apply) begin
            if (r_best_v && r_best_len != size_a) begin
                f_start[r_best] <= r_best_st + size_a;
                f_len[r_best]   <= r_best_len - size_a;
            end
            l_until[slot] <= r_end;
            l_addr[slot]  <= r_best_v ? r_best_st : at;
            l_len[slot]   <= size_a;
        end
        if (i_cmd.load) begin
            r_id    <= i_buffer_id;
            r_begin <= t_step'(i_live_begin);
            r_end   <= t_step'(i_live_end);
            r_size  <= i_reserved_bytes;
        end
        if (i_cmd.fit_apply) o_offset <= 32'(r_best_v ? r_best_st : at);
        else if (i_ok) o_offset <= '0;
        o_placed_id  <= r_id;
        o_high_water <= i_cmd.clear ? '0 :
            32'(i_cmd.fit_apply && !r_best_v ? grow_sum[ADDR_BITS-1:0] : r_water);
    end

    // scan accumulators (one free entry per cycle)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fused <= '0;
            r_lused <= '0;
            r_water <= '0;
            r_prev  <= '0;
            r_fv    <= 1'b0;
            r_left_v <= 1'b0; r_right_v <= 1'b0; r_spare_v <= 1'b0;
            r_best_v <= 1'b0; r_edge_v <= 1'b0;
        end else begin
            r_fv   <= i_cmd.free_rd;
            if (i_cmd.clear) begin
                r_fused <= '0;
                r_lused <= '0;
                r_water <= '0;
            end
            if (i_cmd.set_prev) r_prev <= r_begin;
            else if (i_cmd.clear) r_prev <= '0;
            if (i_cmd.scan_clr) begin
                r_left_v <= 1'b0; r_right_v <= 1'b0; r_spare_v <= 1'b0;
                r_best_v <= 1'b0; r_edge_v <= 1'b0;
            end else if (r_fv) begin
                if (!r_fused[r_fi_d]) begin
                    if (!r_spare_v) begin
                        r_spare_v <= 1'b1;
                        r_spare   <= r_fi_d;
                    end
                end else begin
                    if (r_fs + r_fl == r_la) begin
                        r_left_v <= 1'b1; r_left <= r_fi_d; r_left_len <= r_fl;
                    end else if (r_fs == r_la + r_ll) begin
                        r_right_v <= 1'b1; r_right <= r_fi_d; r_right_len <= r_fl;
                    end
                    if (r_fl >= size_a && (!r_best_v || r_fl < r_best_len ||
                        (r_fl == r_best_len && r_fs < r_best_st))) begin
                        r_best_v <= 1'b1; r_best <= r_fi_d;
                        r_best_len <= r_fl; r_best_st <= r_fs;
                    end
                    if (r_fs + r_fl == r_water) begin
                        r_edge_v <= 1'b1; r_edge <= r_fi_d;
                        r_edge_len <= r_fl; r_edge_st <= r_fs;
                    end
                end
            end
            if (i_cmd.give_apply) begin
                r_lused[i_cmd.live_idx] <= 1'b0;
                if (r_left_v) begin
                    if (r_right_v) r_fused[r_right] <= 1'b0;
                end else if (!r_right_v) begin
                    r_fused[r_spare] <= 1'b1;
                end
            end
            if (i_cmd.fit_apply) begin
                r_lused[slot] <= 1'b1;
                if (r_best_v) begin
                    if (r_best_len == size_a) r_fused[r_best] <= 1'b0;
                end else begin
                    if (r_edge_v) r_fused[r_edge] <= 1'b0;
                    r_water <= grow_sum[ADDR_BITS-1:0];
                end
            end
        end
    end

    `include "lifetime_best_fit_arena_planner_assert.svh"
    `LBF_ASSERT_NEXT(a_water_grows, i_clk, i_rst_n, !i_cmd.clear, r_water >= $past(r_water))
    `LBF_ASSERT_IMP(a_fit_slot, i_clk, i_rst_n, i_cmd.fit_apply, o_stat.slot_found)
    `LBF_ASSERT_IMP(a_give_ok, i_clk, i_rst_n, i_cmd.give_apply, o_stat.give_ok)
endmodule
`default_nettype wire

@@ design/lifetime_best_fit_arena_planner.sv @@
`default_nettype none
// Best-fit arena planner with free-block coalescing. Pulse start while busy is low to
// transfer one request; exactly one result follows, shown for one cycle with o_done high,
// and it cannot be stalled: capture it on that edge. busy drops with o_done, so the next
// request can be taken in the result cycle. The active table is walked one entry at a
// time, and every retirement, plus the final fit, scans the free table one entry a cycle.
// Out-of-order and bad-size requests raise o_done straight from the check state; a full
// free table ends the walk at the retirement that fails.
module lifetime_best_fit_arena_planner (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_first_of_plan,
    input  wire  [15:0] i_buffer_id,
    input  wire  [15:0] i_live_begin,
    input  wire  [15:0] i_live_end,
    input  wire  [31:0] i_reserved_bytes,
    output logic        o_done,
    output logic [15:0] o_placed_id,
    output logic [31:0] o_offset,
    output logic [31:0] o_high_water,
    output logic [2:0]  o_status
);
    import lbfap_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_status st;

    lbfap_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_first(i_first_of_plan),
        .o_busy(busy), .o_done(o_done), .o_status(st), .o_cmd(cmd), .i_stat(stat)
    );

    lbfap_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_buffer_id(i_buffer_id), .i_live_begin(i_live_begin), .i_live_end(i_live_end),
        .i_reserved_bytes(i_reserved_bytes), .i_ok(busy),
        .o_placed_id(o_placed_id), .o_offset(o_offset), .o_high_water(o_high_water)
    );

    assign o_status = st;
endmodule
`default_nettype wire
